// File: sv/lr_pkg.sv
package lr_pkg;

  localparam int COORD_W = 6;
  localparam int GRAY_W  = 8;
  // Major span fits the coordinate width; signed minor delta needs one more bit.
  localparam int SPAN_W  = COORD_W;
  localparam int DELTA_W = COORD_W + 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [GRAY_W-1:0]  gray_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new line command
    logic step;   // advance to the next pixel
  } lr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_zero;  // loaded line has no pixels
    logic last;       // current pixel is the final one
  } lr_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } lr_state_t;

endpackage

// File: sv/lr_if.sv
interface lr_cmd_if import lr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  gray_t  gray_level;

  modport source (output valid, start_x, start_y, end_x, end_y, gray_level, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, gray_level, output ready);
endinterface

interface lr_pixel_if import lr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  gray_t  pixel_value;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_value, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_value, last_pixel, output ready);
endinterface

// File: sv/lr_ctrl.sv
module lr_ctrl import lr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  output logic    pix_valid,
  input  logic    pix_ready,
  input  lr_sts_t sts,
  output lr_cmd_t ctl
);

  lr_state_t state;
  lr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.span_zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (pix_ready && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign cmd_ready = (state == ST_IDLE);
  assign pix_valid = (state == ST_EMIT);
  assign ctl.load  = cmd_ready && cmd_valid;
  assign ctl.step  = pix_valid && pix_ready && !sts.last;

endmodule

// File: sv/lr_datapath.sv
module lr_datapath import lr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  lr_cmd_t ctl,
  output lr_sts_t sts,
  input  coord_t  start_x,
  input  coord_t  start_y,
  input  coord_t  end_x,
  input  coord_t  end_y,
  input  gray_t   gray_level,
  output coord_t  pixel_x,
  output coord_t  pixel_y,
  output gray_t   pixel_value
);

  // Line registers
  coord_t                    major_pos;
  coord_t                    minor_pos;
  logic [SPAN_W-1:0]         major_span;
  logic signed [DELTA_W-1:0] minor_span;
  logic [SPAN_W-1:0]         remain;
  logic [SPAN_W-1:0]         err;
  logic                      x_is_major;
  gray_t                     held_gray;

  // Setup logic on the incoming command
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [COORD_W-1:0]        adx;
  logic [COORD_W-1:0]        ady;
  logic                      xm;
  coord_t                    a1;
  coord_t                    b1;
  coord_t                    a2;
  coord_t                    b2;
  coord_t                    lo_major;
  coord_t                    lo_minor;
  coord_t                    hi_major;
  coord_t                    hi_minor;

  always_comb begin
    dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    adx = dx[DELTA_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady = dy[DELTA_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    xm  = adx > ady;
    a1  = xm ? start_x : start_y;
    b1  = xm ? start_y : start_x;
    a2  = xm ? end_x   : end_y;
    b2  = xm ? end_y   : end_x;
    // Order endpoints so the major coordinate rises.
    if (a2 < a1) begin
      lo_major = a2;
      lo_minor = b2;
      hi_major = a1;
      hi_minor = b1;
    end else begin
      lo_major = a1;
      lo_minor = b1;
      hi_major = a2;
      hi_minor = b2;
    end
  end

  // Incremental floor division: remainder stays in [0, major_span).
  logic signed [DELTA_W:0] err_sum;
  logic [SPAN_W-1:0]       err_next;
  coord_t                  minor_next;

  always_comb begin
    err_sum    = $signed({2'b00, err}) + $signed({minor_span[DELTA_W-1], minor_span});
    err_next   = err_sum[SPAN_W-1:0];
    minor_next = minor_pos;
    priority if (err_sum < 0) begin
      err_next   = SPAN_W'(err_sum + $signed({2'b00, major_span}));
      minor_next = minor_pos - 1'b1;
    end else if (err_sum >= $signed({2'b00, major_span})) begin
      err_next   = SPAN_W'(err_sum - $signed({2'b00, major_span}));
      minor_next = minor_pos + 1'b1;
    end else begin
      err_next   = err_sum[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos  <= '0;
      minor_pos  <= '0;
      major_span <= '0;
      remain     <= '0;
      minor_span <= '0;
      err        <= '0;
      x_is_major <= 1'b0;
      held_gray  <= '0;
    end else if (ctl.load) begin
      major_pos  <= lo_major;
      minor_pos  <= lo_minor;
      major_span <= hi_major - lo_major;
      remain     <= hi_major - lo_major;
      minor_span <= $signed({1'b0, hi_minor}) - $signed({1'b0, lo_minor});
      err        <= '0;
      x_is_major <= xm;
      held_gray  <= gray_level;
    end else if (ctl.step) begin
      major_pos  <= major_pos + 1'b1;
      minor_pos  <= minor_next;
      err        <= err_next;
      remain     <= remain - 1'b1;
    end
  end

  assign sts.span_zero = (major_span == '0);
  assign sts.last      = (remain == SPAN_W'(1));

  assign pixel_x     = x_is_major ? major_pos : minor_pos;
  assign pixel_y     = x_is_major ? minor_pos : major_pos;
  assign pixel_value = held_gray;

endmodule

// File: sv/line_rasterizer_core.sv
// Line rasterizer core.
//
// Channel cmd takes one line command per beat: two endpoints (start_x/start_y,
// end_x/end_y) and a gray_level. Channel pixel returns one pixel write per beat
// along the line's major axis, with last_pixel set on the final beat of a line.
// The endpoint with the higher major coordinate is not drawn; a command whose
// endpoints coincide produces no beats.
//
// After a command is taken the controller passes through ST_CHECK, then offers
// pixels from ST_EMIT; an empty line returns from ST_CHECK to idle. A line holds
// at most 63 pixels. One command is in flight at a time, and cmd.ready is low
// until the last pixel has been taken. For each pixel the minor coordinate
// advances via a running remainder: one add, then a compare-add or -subtract.
//
// When pixel.ready is low the current pixel beat is held unchanged until taken.
// Synchronous reset drops any line in progress and returns to idle with
// cmd.ready high.
module line_rasterizer_core import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lr_cmd_if.sink    cmd,
  lr_pixel_if.source pixel
);

  lr_cmd_t ctl;
  lr_sts_t sts;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .start_x     (cmd.start_x),
    .start_y     (cmd.start_y),
    .end_x       (cmd.end_x),
    .end_y       (cmd.end_y),
    .gray_level  (cmd.gray_level),
    .pixel_x     (pixel.pixel_x),
    .pixel_y     (pixel.pixel_y),
    .pixel_value (pixel.pixel_value)
  );

  assign pixel.last_pixel = sts.last;

endmodule

// File: sim/line_rasterizer_core_tb.sv
`timescale 1ns / 1ps

module line_rasterizer_core_tb import lr_pkg::*; ();

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_LINES = 196;

  typedef struct packed {
    coord_t x;
    coord_t y;
    gray_t  value;
    logic   last;
  } pixel_beat_t;

  // How a directed row is checked: predictor trace, no beats, or one typed-in beat.
  typedef enum logic [1:0] {CHK_MODEL, CHK_EMPTY, CHK_SINGLE} row_check_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

  typedef struct packed {
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    gray_t      gray;
    row_check_t check;
    coord_t     tx;
    coord_t     ty;
  } line_row_t;

  logic clk;
  logic rst;

  lr_cmd_if   cmd_if();
  lr_pixel_if pixel_if();

  line_rasterizer_core uut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .pixel (pixel_if)
  );

  pixel_beat_t pixel_q[$];
  int          fail_cnt   = 0;
  int          burst_left = 0;
  bit          hold_req   = 0;

  line_row_t directed_rows [24] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  8'h00, CHK_EMPTY,  6'd0,  6'd0},
    '{6'd63, 6'd63, 6'd63, 6'd63, 8'hff, CHK_EMPTY,  6'd0,  6'd0},
    '{6'd7,  6'd7,  6'd7,  6'd7,  8'h80, CHK_EMPTY,  6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd1,  6'd0,  8'hff, CHK_SINGLE, 6'd0,  6'd0},
    '{6'd1,  6'd0,  6'd0,  6'd0,  8'haa, CHK_SINGLE, 6'd0,  6'd0},
    '{6'd63, 6'd63, 6'd62, 6'd63, 8'h55, CHK_SINGLE, 6'd62, 6'd63},
    '{6'd0,  6'd0,  6'd0,  6'd1,  8'h01, CHK_SINGLE, 6'd0,  6'd0},
    '{6'd0,  6'd63, 6'd0,  6'd62, 8'hfe, CHK_SINGLE, 6'd0,  6'd62},
    // diagonal tie goes y-major
    '{6'd5,  6'd10, 6'd6,  6'd11, 8'h3c, CHK_SINGLE, 6'd5,  6'd10},
    '{6'd63, 6'd0,  6'd62, 6'd1,  8'hc3, CHK_SINGLE, 6'd63, 6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd0,  8'h55, CHK_MODEL,  6'd0,  6'd0},
    '{6'd63, 6'd0,  6'd0,  6'd0,  8'haa, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd0,  6'd63, 8'h0f, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd63, 6'd0,  6'd0,  8'hf0, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd63, 8'hff, CHK_MODEL,  6'd0,  6'd0},
    '{6'd63, 6'd0,  6'd0,  6'd63, 8'h00, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  8'h81, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd63, 6'd62, 8'h7e, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd0,  6'd62, 6'd63, 8'he7, CHK_MODEL,  6'd0,  6'd0},
    '{6'd63, 6'd0,  6'd0,  6'd1,  8'h18, CHK_MODEL,  6'd0,  6'd0},
    '{6'd0,  6'd63, 6'd1,  6'd0,  8'h24, CHK_MODEL,  6'd0,  6'd0},
    '{6'd10, 6'd20, 6'd50, 6'd5,  8'h99, CHK_MODEL,  6'd0,  6'd0},
    '{6'd40, 6'd40, 6'd3,  6'd60, 8'h66, CHK_MODEL,  6'd0,  6'd0},
    '{6'd42, 6'd21, 6'd21, 6'd42, 8'hbd, CHK_MODEL,  6'd0,  6'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t clip_coord(int v);
    return (v < 0) ? coord_t'(0) : (v > 63) ? coord_t'(63) : coord_t'(v);
  endfunction

  // Walk the major axis from the lower endpoint, excluding the upper one; the minor
  // coordinate is the floored exact quotient of offset times minor delta by span.
  function automatic void trace_line(line_row_t r);
    int x1, y1, x2, y2, adx, ady;
    int a1, b1, a2, b2, t, dmaj, dmin, num, quo, ma, mn;
    bit x_major;
    pixel_beat_t pb;
    x1 = int'(r.sx);
    y1 = int'(r.sy);
    x2 = int'(r.ex);
    y2 = int'(r.ey);
    adx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    ady = (y2 >= y1) ? y2 - y1 : y1 - y2;
    x_major = adx > ady;
    if (x_major) begin
      a1 = x1; b1 = y1; a2 = x2; b2 = y2;
    end else begin
      a1 = y1; b1 = x1; a2 = y2; b2 = x2;
    end
    if (a2 < a1) begin
      t = a1; a1 = a2; a2 = t;
      t = b1; b1 = b2; b2 = t;
    end
    dmaj = a2 - a1;
    dmin = b2 - b1;
    for (int k = 0; k < dmaj; k++) begin
      num = k * dmin;
      quo = (num >= 0) ? num / dmaj : -((dmaj - 1 - num) / dmaj);
      ma = a1 + k;
      mn = b1 + quo;
      pb.x     = x_major ? coord_t'(ma) : coord_t'(mn);
      pb.y     = x_major ? coord_t'(mn) : coord_t'(ma);
      pb.value = r.gray;
      pb.last  = (k == dmaj - 1);
      pixel_q.push_back(pb);
    end
  endfunction

  function automatic line_row_t pick_line();
    line_row_t r;
    int len;
    r = '0;
    r.check = CHK_MODEL;
    r.sx = coord_t'($urandom_range(0, 63));
    r.sy = coord_t'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r.ex = clip_coord(int'(r.sx) + int'($urandom_range(0, 12)) - 6);
        r.ey = clip_coord(int'(r.sy) + int'($urandom_range(0, 12)) - 6);
      end
      4, 5: begin
        r.ex = coord_t'($urandom_range(0, 63));
        r.ey = coord_t'($urandom_range(0, 63));
      end
      6: begin
        r.ex = r.sx;
        r.ey = r.sy;
      end
      7: begin
        if ($urandom_range(0, 1) == 1) begin
          r.ex = coord_t'($urandom_range(0, 63));
          r.ey = r.sy;
        end else begin
          r.ex = r.sx;
          r.ey = coord_t'($urandom_range(0, 63));
        end
      end
      8: begin
        len = int'($urandom_range(1, 20));
        r.ex = clip_coord(($urandom_range(0, 1) == 1) ? int'(r.sx) + len : int'(r.sx) - len);
        r.ey = clip_coord(($urandom_range(0, 1) == 1) ? int'(r.sy) + len : int'(r.sy) - len);
      end
      default: begin
        r.sx = ($urandom_range(0, 1) == 1) ? coord_t'(63) : coord_t'(0);
        r.sy = ($urandom_range(0, 1) == 1) ? coord_t'(63) : coord_t'(0);
        r.ex = ($urandom_range(0, 1) == 1) ? coord_t'(63) : coord_t'(0);
        r.ey = ($urandom_range(0, 1) == 1) ? coord_t'(63) : coord_t'(0);
      end
    endcase
    r.gray = gray_t'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_line(line_row_t r);
    cmd_if.valid      <= 1'b1;
    cmd_if.start_x    <= r.sx;
    cmd_if.start_y    <= r.sy;
    cmd_if.end_x      <= r.ex;
    cmd_if.end_y      <= r.ey;
    cmd_if.gray_level <= r.gray;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    case (r.check)
      CHK_MODEL:  trace_line(r);
      CHK_SINGLE: pixel_q.push_back(pixel_beat_t'{r.tx, r.ty, r.gray, 1'b1});
      default:    ;
    endcase
  endtask

  // Offer commands in bursts; drop valid for a random gap between them.
  task automatic idle_sender();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 40))
                                               : int'($urandom_range(1, 6));
      gap = int'($urandom_range(1, 12));
    end
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_lines();
    cmd_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst               <= 1'b1;
    cmd_if.valid      <= 1'b0;
    cmd_if.start_x    <= '0;
    cmd_if.start_y    <= '0;
    cmd_if.end_x      <= '0;
    cmd_if.end_y      <= '0;
    cmd_if.gray_level <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_line(directed_rows[i]);
      idle_sender();
    end
    drain_lines();

    for (int n = 0; n < RANDOM_LINES; n++) begin
      // hold the pixel side off while commands keep coming
      if (n == 40 || n == 150) hold_req = 1'b1;
      if (n == 100) drain_lines();
      send_line(pick_line());
      idle_sender();
    end
    drain_lines();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    sink_mode_t mode;
    int left;
    mode = SINK_OPEN;
    left = 0;
    pixel_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pixel_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          left = int'($urandom_range(10, 80));
        end
        left--;
        case (mode)
          SINK_OPEN:   pixel_if.ready <= 1'b1;
          SINK_COIN:   pixel_if.ready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: pixel_if.ready <= ($urandom_range(0, 3) == 0);
          default:     pixel_if.ready <= ~pixel_if.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst && pixel_if.valid && pixel_if.ready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with none expected: x=%0d y=%0d value=%0d last=%0b",
               pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.pixel_value,
               pixel_if.last_pixel);
        fail_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_if.pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pixel_if.pixel_x);
          fail_cnt++;
        end
        if (pixel_if.pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pixel_if.pixel_y);
          fail_cnt++;
        end
        if (pixel_if.pixel_value !== want.value) begin
          $error("pixel_value: expected %0d, got %0d", want.value, pixel_if.pixel_value);
          fail_cnt++;
        end
        if (pixel_if.last_pixel !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, pixel_if.last_pixel);
          fail_cnt++;
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (pixel_if.valid && pixel_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
